@@ hdl/radial_stick_dead_zone_unit_defines.svh @@
// Assertion macros shared by the radial stick dead-zone RTL.
`ifndef RADIAL_STICK_DEAD_ZONE_UNIT_DEFINES_SVH
`define RADIAL_STICK_DEAD_ZONE_UNIT_DEFINES_SVH

// Checked property, disabled while reset is high.
`define RSDZ_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rsdz assertion failed");

// Checked property, also evaluated during reset.
`define RSDZ_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("rsdz reset assertion failed");

`endif

@@ hdl/rsdz_pkg.sv @@
// Types and constants of the radial stick dead-zone datapath.
package rsdz_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int OUT_FRAC_BITS = 15;
   localparam int MAG_FRAC      = 8;

   localparam int AW    = SAMPLE_BITS;
   localparam int DZW   = SAMPLE_BITS - 1;
   localparam int SQW   = 2 * SAMPLE_BITS - 1;
   localparam int SW    = 2 * SAMPLE_BITS;
   localparam int RW    = SW + 2 * MAG_FRAC;
   localparam int MW    = RW / 2;
   localparam int REMW  = MW + 3;
   localparam int DENW  = MW + DZW;
   localparam int NW    = AW + MW + OUT_FRAC_BITS;
   localparam int QW    = OUT_FRAC_BITS;
   localparam int OW    = OUT_FRAC_BITS + 1;
   localparam int CSRW  = 2;

   localparam logic [DZW-1:0] SAMPLE_MAX = {DZW{1'b1}};
   localparam logic [SW-1:0]  SAMPLE_MAX_SQ = SW'(SAMPLE_MAX) * SW'(SAMPLE_MAX);
   localparam logic [OW-1:0]  OUT_MIN = {1'b1, {(OW-1){1'b0}}};
   localparam logic [DZW-1:0] LEFT_DZ_RESET  = DZW'(7849);
   localparam logic [DZW-1:0] RIGHT_DZ_RESET = DZW'(8689);

   localparam logic [CSRW-1:0] CSR_LEFT_DZ  = CSRW'(0);
   localparam logic [CSRW-1:0] CSR_RIGHT_DZ = CSRW'(1);

   typedef struct packed {
      logic [AW-1:0]  ax;
      logic [AW-1:0]  ay;
      logic           xneg;
      logic           yneg;
      logic [DZW-1:0] dz;
      logic           dead;
      logic           clipped;
   } ctx_type;

   typedef struct packed {
      logic [REMW-1:0] rem;
      logic [MW-1:0]   root;
      logic [RW-1:0]   rad;
   } sq_type;

   typedef struct packed {
      logic [NW-1:0]   rem;
      logic [QW-1:0]   quo;
      logic [DENW-1:0] den;
   } div_type;

endpackage

@@ hdl/rsdz_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
module rsdz_sqrt_cell
   import rsdz_pkg::*;
(
   input  logic   clock,
   input  logic   en,
   input  sq_type sq_in,
   output sq_type sq_out
);

   logic [REMW-1:0] rem_sh;
   logic [REMW-1:0] trial;
   sq_type          sq_out_ff;
   sq_type          sq_out_in;

   always_comb begin
      rem_sh = {sq_in.rem[REMW-3:0], sq_in.rad[RW-1:RW-2]};
      trial  = {1'b0, sq_in.root, 2'b01};
      sq_out_in.rad = {sq_in.rad[RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
         sq_out_in.rem  = rem_sh - trial;
         sq_out_in.root = {sq_in.root[MW-2:0], 1'b1};
      end else begin
         sq_out_in.rem  = rem_sh;
         sq_out_in.root = {sq_in.root[MW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_out_ff <= sq_out_in;
      end
   end

   assign sq_out = sq_out_ff;

endmodule

@@ hdl/rsdz_div_cell.sv @@
// One quotient bit of the pipelined restoring divider.
module rsdz_div_cell
   import rsdz_pkg::*;
#(
   parameter int BIT_POS = 0
)
(
   input  logic    clock,
   input  logic    en,
   input  div_type dv_in,
   output div_type dv_out
);

   logic [NW-1:0] den_sh;
   div_type       dv_out_ff;
   div_type       dv_out_in;

   always_comb begin
      den_sh = NW'(dv_in.den) << BIT_POS;
      dv_out_in.den = dv_in.den;
      if (dv_in.rem >= den_sh) begin
         dv_out_in.rem = dv_in.rem - den_sh;
         dv_out_in.quo = {dv_in.quo[QW-2:0], 1'b1};
      end else begin
         dv_out_in.rem = dv_in.rem;
         dv_out_in.quo = {dv_in.quo[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_out_ff <= dv_out_in;
      end
   end

   assign dv_out = dv_out_ff;

endmodule

@@ hdl/radial_stick_dead_zone_unit.sv @@
// Top level of the radial stick dead-zone unit: input stages, root and divider chains, output.
//
// The req channel carries one stick sample pair per word: x_sample in tdata[15:0],
// y_sample in tdata[31:16], and stick_select in tuser (0 left, 1 right dead zone).
// The rsp channel returns one word per request: out_x in tdata[15:0], out_y in
// tdata[31:16], both signed Q1.15, and in_dead_zone in tuser.
// The csr channel writes the dead-zone radii: index 0 is the left stick, index 1
// the right stick, other indexes are ignored. Write only while the unit is idle.
// A word passes 46 register stages: three input stages, one stage per root bit (24),
// three product stages, one stage per quotient bit (15) and the output register.
// The first stage loads at the accepting edge, and rsp_tvalid rises once the word reaches the output register.
// One word is accepted every cycle while req_tready is high.
// All stages advance together; when rsp_tvalid is high and rsp_tready is low the
// whole chain holds and req_tready drops in the same cycle, so nothing is lost.
// Reset empties the chain and loads the default radii 7849 and 8689.
`include "radial_stick_dead_zone_unit_defines.svh"
module radial_stick_dead_zone_unit
   import rsdz_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*SAMPLE_BITS-1:0] req_tdata,  // x_sample, y_sample
   input  logic                    req_tuser,  // stick_select
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [2*OW-1:0]         rsp_tdata,  // out_x, out_y
   output logic                    rsp_tuser,  // in_dead_zone
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSRW-1:0]         csr_index,
   input  logic [DZW-1:0]          csr_data
);

   localparam int ST_ROOT = 2 + MW;
   localparam int ST_DE   = ST_ROOT + 1;
   localparam int ST_PROD = ST_ROOT + 2;
   localparam int ST_NUM  = ST_ROOT + 3;
   localparam int ST_QUO  = ST_NUM + QW;

   logic [DZW-1:0] left_dz_ff;
   logic [DZW-1:0] right_dz_ff;
   logic           en;
   logic [ST_QUO:0] vld_ff;
   ctx_type        ctx_ff [0:ST_QUO];
   ctx_type        ctx0_in;
   ctx_type        ctx2_in;
   logic [SAMPLE_BITS-1:0] x_in;
   logic [SAMPLE_BITS-1:0] y_in;

   logic [SQW-1:0]  sqx_ff;
   logic [SQW-1:0]  sqy_ff;
   logic [SQW-2:0]  dzsq_ff;
   logic [SW-1:0]   s_in;
   logic [SW-1:0]   s_ff;
   sq_type          sq_w [0:MW];

   logic [MW-1:0]   d_ff;
   logic [DZW-1:0]  e_ff;
   logic [MW-1:0]   m_ff;
   logic [AW+MW-1:0] pax_ff;
   logic [AW+MW-1:0] pay_ff;
   logic [DENW-1:0] den_ff;
   logic [NW-1:0]   nx_ff;
   logic [NW-1:0]   ny_ff;
   logic [DENW-1:0] den2_ff;
   div_type         dvx_w [0:QW];
   div_type         dvy_w [0:QW];

   logic            rsp_valid_ff;
   logic            rsp_dead_ff;
   logic [OW-1:0]   rsp_x_ff;
   logic [OW-1:0]   rsp_y_ff;
   logic [OW-1:0]   qx_ext;
   logic [OW-1:0]   qy_ext;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff  <= LEFT_DZ_RESET;
         right_dz_ff <= RIGHT_DZ_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEFT_DZ:  left_dz_ff  <= csr_data;
            CSR_RIGHT_DZ: right_dz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Stage 0: absolute values and radius select.
   always_comb begin
      x_in = req_tdata[SAMPLE_BITS-1:0];
      y_in = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      ctx0_in.xneg    = x_in[SAMPLE_BITS-1];
      ctx0_in.yneg    = y_in[SAMPLE_BITS-1];
      ctx0_in.ax      = x_in[SAMPLE_BITS-1] ? (~x_in + AW'(1)) : x_in;
      ctx0_in.ay      = y_in[SAMPLE_BITS-1] ? (~y_in + AW'(1)) : y_in;
      ctx0_in.dz      = req_tuser ? right_dz_ff : left_dz_ff;
      ctx0_in.dead    = 1'b0;
      ctx0_in.clipped = 1'b0;
   end

   // Stage 2: radius compare and clip flags.
   always_comb begin
      s_in = SW'(sqx_ff) + SW'(sqy_ff);
      ctx2_in = ctx_ff[1];
      ctx2_in.dead    = s_in <= SW'(dzsq_ff);
      ctx2_in.clipped = s_in > SAMPLE_MAX_SQ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ST_QUO-1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0] <= ctx0_in;
         ctx_ff[1] <= ctx_ff[0];
         ctx_ff[2] <= ctx2_in;
         for (int i = 3; i <= ST_QUO; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
         sqx_ff    <= SQW'(ctx_ff[0].ax) * SQW'(ctx_ff[0].ax);
         sqy_ff    <= SQW'(ctx_ff[0].ay) * SQW'(ctx_ff[0].ay);
         dzsq_ff   <= (SQW-1)'(ctx_ff[0].dz) * (SQW-1)'(ctx_ff[0].dz);
         s_ff      <= s_in;
      end
   end

   genvar gi;

   // Square root of s scaled by 2^(2*MAG_FRAC), one root bit per cell.
   always_comb begin
      sq_w[0].rem  = '0;
      sq_w[0].root = '0;
      sq_w[0].rad  = {s_ff, {(2*MAG_FRAC){1'b0}}};
   end

   generate
      for (gi = 0; gi < MW; gi++) begin : g_sqrt
         rsdz_sqrt_cell u_cell (
            .clock  (clock),
            .en     (en),
            .sq_in  (sq_w[gi]),
            .sq_out (sq_w[gi+1])
         );
      end
   endgenerate

   // Numerator and denominator of the scale factor.
   always_ff @(posedge clock) begin
      if (en) begin
         m_ff <= sq_w[MW].root;
         if (ctx_ff[ST_ROOT].clipped) begin
            d_ff <= MW'(1) << MAG_FRAC;
            e_ff <= DZW'(1);
         end else begin
            d_ff <= sq_w[MW].root - (MW'(ctx_ff[ST_ROOT].dz) << MAG_FRAC);
            e_ff <= SAMPLE_MAX - ctx_ff[ST_ROOT].dz;
         end
         pax_ff  <= (AW+MW)'(ctx_ff[ST_DE].ax) * (AW+MW)'(d_ff);
         pay_ff  <= (AW+MW)'(ctx_ff[ST_DE].ay) * (AW+MW)'(d_ff);
         den_ff  <= DENW'(m_ff) * DENW'(e_ff);
         nx_ff   <= (NW'(pax_ff) << OUT_FRAC_BITS) - NW'(pax_ff);
         ny_ff   <= (NW'(pay_ff) << OUT_FRAC_BITS) - NW'(pay_ff);
         den2_ff <= den_ff;
      end
   end

   // Restoring division, one quotient bit per cell, one chain per axis.
   always_comb begin
      dvx_w[0].rem = nx_ff;
      dvx_w[0].quo = '0;
      dvx_w[0].den = den2_ff;
      dvy_w[0].rem = ny_ff;
      dvy_w[0].quo = '0;
      dvy_w[0].den = den2_ff;
   end

   generate
      for (gi = 0; gi < QW; gi++) begin : g_div
         rsdz_div_cell #(.BIT_POS(QW - 1 - gi)) u_cell_x (
            .clock  (clock),
            .en     (en),
            .dv_in  (dvx_w[gi]),
            .dv_out (dvx_w[gi+1])
         );
         rsdz_div_cell #(.BIT_POS(QW - 1 - gi)) u_cell_y (
            .clock  (clock),
            .en     (en),
            .dv_in  (dvy_w[gi]),
            .dv_out (dvy_w[gi+1])
         );
      end
   endgenerate

   // Sign restore and output register.
   assign qx_ext = OW'(dvx_w[QW].quo);
   assign qy_ext = OW'(dvy_w[QW].quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[ST_QUO];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_dead_ff <= ctx_ff[ST_QUO].dead;
         if (ctx_ff[ST_QUO].dead) begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
         end else begin
            rsp_x_ff <= ctx_ff[ST_QUO].xneg ? (~qx_ext + OW'(1)) : qx_ext;
            rsp_y_ff <= ctx_ff[ST_QUO].yneg ? (~qy_ext + OW'(1)) : qy_ext;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_dead_ff;

   `RSDZ_ASSERT(a_dead_gives_zero, rsp_valid_ff && rsp_dead_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0)
   `RSDZ_ASSERT(a_no_min_code, rsp_valid_ff |-> rsp_x_ff != OUT_MIN && rsp_y_ff != OUT_MIN)
   `RSDZ_ASSERT(a_chain_holds, !en |=> $stable(vld_ff) && $stable(rsp_x_ff))
   `RSDZ_ASSERT(a_clip_not_dead_root, vld_ff[ST_ROOT] && !ctx_ff[ST_ROOT].dead |-> sq_w[MW].root >= (MW'(ctx_ff[ST_ROOT].dz) << MAG_FRAC))
   `RSDZ_ASSERT_RST(a_reset_empties, $past(reset) |-> !rsp_valid_ff && vld_ff == '0)

endmodule
